/* rtl/core/kphd_pkg.sv */
package kphd_pkg;

    localparam int KEYPOINTS = 17;
    localparam int GRID      = 9;
    localparam int GRID_DIV  = GRID - 1;
    localparam int TOTAL     = KEYPOINTS * GRID * GRID;

    localparam int KP_W    = 5;
    localparam int CELL_W  = 4;
    localparam int CNT_W   = 11;
    localparam int SIZE_W  = 13;
    localparam int DATA_W  = 16;
    localparam int LOC_W   = 14;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam int BASE_W  = CELL_W + SIZE_W;
    localparam int SUM_W   = BASE_W + 5;

    localparam logic REG_MAIN_WIDTH  = 1'b0;
    localparam logic REG_MAIN_HEIGHT = 1'b1;

    localparam int LOC_MIN = -2048;
    localparam int LOC_MAX = 6144;

    // one word handed from the front end to the back end
    typedef struct packed {
        logic signed [DATA_W-1:0] score;
        logic signed [DATA_W-1:0] offset_y;
        logic signed [DATA_W-1:0] offset_x;
        logic [KP_W-1:0]          kp;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic                     first;
        logic                     upd;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] score;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic signed [DATA_W-1:0] offset_y;
        logic signed [DATA_W-1:0] offset_x;
    } best_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPD,
        BK_EMIT_RD,
        BK_EMIT_OUT
    } back_state_t;

endpackage

/* rtl/core/pose_keypoint_heatmap_decoder_top.sv */
// keypoint heatmap decoder: running per-keypoint argmax over a 9x9 grid, 17 keypoints
// input channel s_*: one word per cell and keypoint, cells row-major, keypoints inner;
// s_frame_end marks the final word of the frame. result channel m_*: on s_frame_end,
// 17 words go out, keypoint 0 first, m_result_last on keypoint 16.
// location = trunc(floor(cell * size / 8) + offset / 16), clamped to [-2048, 6144];
// main_width (addr 0x0) and main_height (addr 0x4) set the image size, write only when idle.
// per input word, the back end does a store read and then a compare and write
// of the keypoint store; a 2-word queue lets s_ready stay high while the back
// end catches up. each result takes a store read, then location math into the
// output register.
// after the frame_end word is taken, the first result passes the update state,
// the store read and the output register. words past the 81st cell of a frame are dropped.
// when m_ready is low the result holds and the back end waits; input words keep
// filling the queue until it is full, then s_ready drops.
// reset: counters, queue and handshakes clear; registers go to 640 x 480; the
// store needs no clearing since the first cell of each frame overwrites it.
module pose_keypoint_heatmap_decoder_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [kphd_pkg::DATA_W-1:0]   s_score,
    input  logic signed [kphd_pkg::DATA_W-1:0]   s_offset_y,
    input  logic signed [kphd_pkg::DATA_W-1:0]   s_offset_x,
    input  logic                                 s_frame_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [kphd_pkg::KP_W-1:0]            m_keypoint,
    output logic signed [kphd_pkg::DATA_W-1:0]   m_confidence,
    output logic signed [kphd_pkg::LOC_W-1:0]    m_location_x,
    output logic signed [kphd_pkg::LOC_W-1:0]    m_location_y,
    output logic                                 m_result_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kphd_pkg::ADDR_W-1:0]          paddr,
    input  logic [kphd_pkg::PDATA_W-1:0]         pwdata,
    output logic [kphd_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import kphd_pkg::*;

    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic              cfg_wr;
    logic              reg_sel;

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_not_empty;
    item_t push_item;
    item_t pop_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            if (reg_sel == REG_MAIN_WIDTH) begin
                width_next = pwdata[SIZE_W-1:0];
            end else begin
                height_next = pwdata[SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_MAIN_HEIGHT) begin
            prdata = {{(PDATA_W - SIZE_W){1'b0}}, height_reg};
        end else begin
            prdata = {{(PDATA_W - SIZE_W){1'b0}}, width_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    kphd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_score     (s_score),
        .s_offset_y  (s_offset_y),
        .s_offset_x  (s_offset_x),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    kphd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    kphd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .main_width    (width_reg),
        .main_height   (height_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_keypoint    (m_keypoint),
        .m_confidence  (m_confidence),
        .m_location_x  (m_location_x),
        .m_location_y  (m_location_y),
        .m_result_last (m_result_last)
    );

endmodule

/* rtl/core/kphd_front.sv */
module kphd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [kphd_pkg::DATA_W-1:0]  s_score,
    input  logic signed [kphd_pkg::DATA_W-1:0]  s_offset_y,
    input  logic signed [kphd_pkg::DATA_W-1:0]  s_offset_x,
    input  logic                                s_frame_end,
    input  logic                                q_full,
    output logic                                q_push,
    output kphd_pkg::item_t                     q_item
);
    import kphd_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KP_W-1:0]   kp_reg, kp_next;
    logic [CELL_W-1:0] cx_reg, cx_next;
    logic [CELL_W-1:0] cy_reg, cy_next;
    logic              in_grid;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign in_grid = cnt_reg < CNT_W'(TOTAL);

    always_comb begin
        q_item.score    = s_score;
        q_item.offset_y = s_offset_y;
        q_item.offset_x = s_offset_x;
        q_item.kp       = kp_reg;
        q_item.cell_x   = cx_reg;
        q_item.cell_y   = cy_reg;
        q_item.first    = cnt_reg < CNT_W'(KEYPOINTS);
        q_item.upd      = in_grid;
        q_item.last     = s_frame_end;
    end

    // keypoint inner, then cell x, then cell y
    always_comb begin
        cnt_next = cnt_reg;
        kp_next  = kp_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        if (q_push) begin
            if (s_frame_end) begin
                cnt_next = '0;
                kp_next  = '0;
                cx_next  = '0;
                cy_next  = '0;
            end else if (in_grid) begin
                cnt_next = cnt_reg + 1'b1;
                if (kp_reg == KP_W'(KEYPOINTS - 1)) begin
                    kp_next = '0;
                    if (cx_reg == CELL_W'(GRID - 1)) begin
                        cx_next = '0;
                        cy_next = cy_reg + 1'b1;
                    end else begin
                        cx_next = cx_reg + 1'b1;
                    end
                end else begin
                    kp_next = kp_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            kp_reg  <= '0;
            cx_reg  <= '0;
            cy_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            kp_reg  <= kp_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

endmodule

/* rtl/core/kphd_queue.sv */
module kphd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  kphd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output kphd_pkg::item_t pop_item
);
    import kphd_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* rtl/core/kphd_back.sv */
module kphd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_not_empty,
    input  kphd_pkg::item_t                     q_item,
    output logic                                q_pop,
    input  logic [kphd_pkg::SIZE_W-1:0]         main_width,
    input  logic [kphd_pkg::SIZE_W-1:0]         main_height,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kphd_pkg::KP_W-1:0]           m_keypoint,
    output logic signed [kphd_pkg::DATA_W-1:0]  m_confidence,
    output logic signed [kphd_pkg::LOC_W-1:0]   m_location_x,
    output logic signed [kphd_pkg::LOC_W-1:0]   m_location_y,
    output logic                                m_result_last
);
    import kphd_pkg::*;

    function automatic logic signed [LOC_W-1:0] locate(
        input logic [CELL_W-1:0]        cell_idx,
        input logic [SIZE_W-1:0]        size,
        input logic signed [DATA_W-1:0] off
    );
        logic [BASE_W-1:0]        base;
        logic signed [SUM_W-1:0]  s;
        logic signed [SUM_W-1:0]  q;
        base = BASE_W'((BASE_W'(cell_idx) * BASE_W'(size)) / GRID_DIV);
        s = $signed({1'b0, base, 4'b0000}) + SUM_W'(off);
        // round toward zero before dropping the fraction
        if (s < 0) begin
            s = s + SUM_W'(15);
        end
        q = s >>> 4;
        if (q < SUM_W'(LOC_MIN)) begin
            q = SUM_W'(LOC_MIN);
        end else if (q > SUM_W'(LOC_MAX)) begin
            q = SUM_W'(LOC_MAX);
        end
        return q[LOC_W-1:0];
    endfunction

    back_state_t state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic [KP_W-1:0] idx_reg, idx_next;

    best_t           store [KEYPOINTS];
    best_t           rd_data_reg;
    logic [KP_W-1:0] rd_addr;
    logic            wr_en;
    best_t           wr_data;

    logic                     m_valid_reg, m_valid_next;
    logic [KP_W-1:0]          kp_out_reg;
    logic signed [DATA_W-1:0] conf_reg;
    logic signed [LOC_W-1:0]  loc_x_reg;
    logic signed [LOC_W-1:0]  loc_y_reg;
    logic                     last_out_reg;
    logic                     out_load;

    assign m_valid       = m_valid_reg;
    assign m_keypoint    = kp_out_reg;
    assign m_confidence  = conf_reg;
    assign m_location_x  = loc_x_reg;
    assign m_location_y  = loc_y_reg;
    assign m_result_last = last_out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_not_empty) begin
                    state_next = BK_UPD;
                end
            end
            BK_UPD: begin
                state_next = cur_reg.last ? BK_EMIT_RD : BK_IDLE;
            end
            BK_EMIT_RD: begin
                state_next = BK_EMIT_OUT;
            end
            BK_EMIT_OUT: begin
                if (out_load) begin
                    state_next = (idx_reg == KP_W'(KEYPOINTS - 1)) ? BK_IDLE : BK_EMIT_RD;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        cur_next = cur_reg;
        idx_next = idx_reg;
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        out_load = 1'b0;
        wr_data.score    = cur_reg.score;
        wr_data.cell_x   = cur_reg.cell_x;
        wr_data.cell_y   = cur_reg.cell_y;
        wr_data.offset_y = cur_reg.offset_y;
        wr_data.offset_x = cur_reg.offset_x;
        case (state_reg)
            BK_IDLE: begin
                q_pop    = q_not_empty;
                cur_next = q_item;
                rd_addr  = q_item.kp;
            end
            BK_UPD: begin
                // first cell writes unconditionally, later cells only on a strictly higher score
                wr_en    = cur_reg.upd && (cur_reg.first || cur_reg.score > rd_data_reg.score);
                idx_next = '0;
            end
            BK_EMIT_RD: begin
                rd_addr = idx_reg;
            end
            BK_EMIT_OUT: begin
                out_load = !m_valid_reg || m_ready;
                if (out_load) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[cur_reg.kp] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (out_load) begin
            kp_out_reg   <= idx_reg;
            conf_reg     <= rd_data_reg.score;
            loc_x_reg    <= locate(rd_data_reg.cell_x, main_width, rd_data_reg.offset_x);
            loc_y_reg    <= locate(rd_data_reg.cell_y, main_height, rd_data_reg.offset_y);
            last_out_reg <= idx_reg == KP_W'(KEYPOINTS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
